### hdl/dgja_pkg.sv
package dgja_pkg;

   localparam int ID_W     = 8;
   localparam int DUR_W    = 8;
   localparam int DL_W     = 8;
   localparam int PROFIT_W = 20;
   localparam int TIME_W   = 12;
   localparam int SUM_W    = 24;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   // one stored job, 44 bits
   typedef struct packed {
      logic [PROFIT_W-1:0] profit;
      logic [DL_W-1:0]     deadline;
      logic [DUR_W-1:0]    duration;
      logic [ID_W-1:0]     job_id;
   } job_type;

   typedef struct packed {
      logic clear;
      logic step;
   } admit_ctl_type;

   typedef struct packed {
      logic              accepted;
      logic [TIME_W-1:0] finish_time;
      logic [SUM_W-1:0]  total_profit;
      logic [SUM_W-1:0]  total_loss;
   } admit_res_type;

endpackage

### hdl/dgja_job_mem.sv
module dgja_job_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  dgja_pkg::job_type    wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output dgja_pkg::job_type    rd_data
);

   dgja_pkg::job_type mem [DEPTH];
   dgja_pkg::job_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dgja_admit.sv
module dgja_admit (
   input  logic                    clock,
   input  logic                    reset,
   input  dgja_pkg::admit_ctl_type ctl,
   input  dgja_pkg::job_type       entry,
   output dgja_pkg::admit_res_type res
);

   logic [dgja_pkg::TIME_W-1:0] now_ff, now_in;
   logic [dgja_pkg::SUM_W-1:0]  gain_ff, gain_in;
   logic [dgja_pkg::SUM_W-1:0]  loss_ff, loss_in;

   logic [dgja_pkg::TIME_W:0]  end_time;
   logic [dgja_pkg::TIME_W:0]  limit;
   logic                        fits;
   logic [dgja_pkg::SUM_W:0]   gain_sum;
   logic [dgja_pkg::SUM_W:0]   loss_sum;

   // deadline in whole hours compared as sixteenths
   assign end_time = {1'b0, now_ff} + {5'b0, entry.duration};
   assign limit    = {1'b0, entry.deadline, 4'b0};
   assign fits     = (end_time <= limit);

   assign gain_sum = {1'b0, gain_ff} + {5'b0, entry.profit};
   assign loss_sum = {1'b0, loss_ff} + {5'b0, entry.profit};

   always_comb begin
      now_in  = now_ff;
      gain_in = gain_ff;
      loss_in = loss_ff;
      if (fits) begin
         now_in  = end_time[dgja_pkg::TIME_W-1:0];
         gain_in = gain_sum[dgja_pkg::SUM_W] ? '1 : gain_sum[dgja_pkg::SUM_W-1:0];
      end else begin
         loss_in = loss_sum[dgja_pkg::SUM_W] ? '1 : loss_sum[dgja_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         now_ff  <= '0;
         gain_ff <= '0;
         loss_ff <= '0;
      end else if (ctl.step) begin
         now_ff  <= now_in;
         gain_ff <= gain_in;
         loss_ff <= loss_in;
      end
   end

   // totals after this job's decision
   assign res.accepted     = fits;
   assign res.finish_time  = now_in;
   assign res.total_profit = gain_in;
   assign res.total_loss   = loss_in;

endmodule

### hdl/deadline_greedy_job_admission.sv
// deadline-ordered greedy job admission
// req channel: one word per job; req_tdata holds job id, duration (1/16 hour),
// deadline (whole hours) and profit, req_tlast marks the last job of a set.
// each job is inserted into a sorted job memory as it arrives (deadline up,
// then profit down, then arrival order): stored jobs are read from the tail
// down and each one that the new job goes ahead of moves up a slot, then the
// job is written into the gap (straight in when the store is empty); a job
// dropped on a full store sets the drop flag. one shift per cycle goes
// through the single read and single write memory port.
// after the last job the set is scheduled: each stored job is read back in
// order, admitted if it still meets its deadline, and one rsp word goes out
// per job with running totals; the next job is read once the word is taken.
// rsp_tuser flags a set in which jobs arrived beyond capacity and were dropped,
// rsp_tlast marks the final result; the store is then empty for the next set.
// req_tready is high only while the block is idle, so no job is taken during
// insertion or while results are out. a stalled result holds in the output
// register until taken. reset empties the store and clears the drop flag; the
// memory itself needs no clearing since only entries below the count are read.
module deadline_greedy_job_admission #(
   parameter int MAX_JOBS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // job_id[7:0], duration[15:8], deadline[23:16], profit[43:24], zero[47:44]
   input  logic [dgja_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // result_id[7:0], accepted[8], finish_time[20:9], total_profit[44:21],
   // total_loss[68:45], zero[71:69]
   output logic [dgja_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // dropped_jobs[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   localparam int ADDR_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_SHIFT      = 3'd1;
   localparam logic [2:0] ST_PLACE      = 3'd2;
   localparam logic [2:0] ST_SCHED_RD   = 3'd3;
   localparam logic [2:0] ST_SCHED_CALC = 3'd4;
   localparam logic [2:0] ST_SCHED_OUT  = 3'd5;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   dgja_pkg::job_type         new_job_ff, new_job_in;
   logic [dgja_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   dgja_pkg::admit_res_type   rsp_res_ff, rsp_res_in;
   logic                      rsp_drop_ff, rsp_drop_in;
   logic                      rsp_last_ff, rsp_last_in;

   // memory and admission unit hookup
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   dgja_pkg::job_type       wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   dgja_pkg::job_type       rd_data;
   dgja_pkg::admit_ctl_type admit_ctl;
   dgja_pkg::admit_res_type admit_res;

   dgja_pkg::job_type req_job;
   logic              req_take;
   logic              new_first;
   logic [CNT_W-1:0]  pos_m1;
   logic [CNT_W-1:0]  pos_m2;
   logic [CNT_W-1:0]  count_m1;
   logic [CNT_W-1:0]  k_p1;

   assign req_job  = req_tdata[$bits(dgja_pkg::job_type)-1:0];
   assign req_take = req_tvalid && req_tready;
   assign pos_m1   = pos_ff - CNT_W'(1);
   assign pos_m2   = pos_ff - CNT_W'(2);
   assign count_m1 = count_ff - CNT_W'(1);
   assign k_p1     = k_ff + CNT_W'(1);

   // new job goes ahead of the stored one: earlier deadline, or same deadline
   // and strictly higher profit; a full tie keeps arrival order
   assign new_first = (new_job_ff.deadline < rd_data.deadline) ||
                      ((new_job_ff.deadline == rd_data.deadline) &&
                       (new_job_ff.profit > rd_data.profit));

   dgja_job_mem #(
      .DEPTH  (MAX_JOBS),
      .ADDR_W (ADDR_W)
   ) u_job_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dgja_admit u_admit (
      .clock (clock),
      .reset (reset),
      .ctl   (admit_ctl),
      .entry (rd_data),
      .res   (admit_res)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      new_job_in   = new_job_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;

      wr_en   = 1'b0;
      wr_addr = pos_ff[ADDR_W-1:0];
      wr_data = new_job_ff;
      rd_en   = 1'b0;
      rd_addr = count_m1[ADDR_W-1:0];

      // running totals start over while idle
      admit_ctl.clear = (state_ff == ST_IDLE);
      admit_ctl.step  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            k_in = '0;
            if (req_take) begin
               new_job_in = req_job;
               last_in    = req_tlast;
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  pos_in = count_ff;
                  if (count_ff != '0) begin
                     // fetch the current tail to compare against
                     rd_en    = 1'b1;
                     rd_addr  = count_m1[ADDR_W-1:0];
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_PLACE;
                  end
               end else begin
                  // store full: job is dropped, a last mark still schedules
                  overflow_in = 1'b1;
                  state_in    = req_tlast ? ST_SCHED_RD : ST_IDLE;
               end
            end
         end

         ST_SHIFT: begin
            if (new_first) begin
               // move the stored job up one slot, fetch the next one down
               wr_en   = 1'b1;
               wr_addr = pos_ff[ADDR_W-1:0];
               wr_data = rd_data;
               pos_in  = pos_m1;
               if (pos_ff == CNT_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_m2[ADDR_W-1:0];
               end
            end else begin
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[ADDR_W-1:0];
            wr_data  = new_job_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = last_ff ? ST_SCHED_RD : ST_IDLE;
         end

         ST_SCHED_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff[ADDR_W-1:0];
            state_in = ST_SCHED_CALC;
         end

         ST_SCHED_CALC: begin
            // decide on this job and register the result word
            admit_ctl.step = 1'b1;
            rsp_id_in      = rd_data.job_id;
            rsp_res_in     = admit_res;
            rsp_drop_in    = overflow_ff;
            rsp_last_in    = (k_p1 == count_ff);
            rsp_valid_in   = 1'b1;
            state_in       = ST_SCHED_OUT;
         end

         ST_SCHED_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // set done: empty the store for the next one
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  k_in     = k_p1;
                  state_in = ST_SCHED_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         pos_ff       <= '0;
         k_ff         <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_job_ff  <= new_job_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0,
                        rsp_res_ff.total_loss,
                        rsp_res_ff.total_profit,
                        rsp_res_ff.finish_time,
                        rsp_res_ff.accepted,
                        rsp_id_ff};
   assign rsp_tuser  = rsp_drop_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hdl/dgja_checker.sv
module dgja_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic [dgja_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // no result pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // no job is taken while a result is out
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("job accepted while result pending");

   // more results follow a non-final one, so the block stays busy
   a_busy_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("block went idle in the middle of a result set");

endmodule

bind deadline_greedy_job_admission dgja_checker u_dgja_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
